// File: hdl/pending_packet_table_core_defines.svh
// ----------------------------------------------------------------------------
// pending_packet_table_core_defines
// assertion macros shared by the pending packet table rtl
// ----------------------------------------------------------------------------
`ifndef PENDING_PACKET_TABLE_CORE_DEFINES_SVH
`define PENDING_PACKET_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PPT_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// sizes, codes and transfer types of the pending packet table
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 64;
  localparam int MKEY_W      = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = KEY_BITS + 1;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // command transfer
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              pkt_type;
    logic [MKEY_W-1:0] match_key;
  } ppt_in_t;

  // result transfer
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [OCC_W-1:0]    occupancy;
  } ppt_out_t;

  // scan outcome handed from the scanner to the control
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
  } ppt_scan_res_t;

endpackage

`default_nettype wire

// File: hdl/ppt_ram.sv
// ----------------------------------------------------------------------------
// ppt_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read-first registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hdl/ppt_scan.sv
// ----------------------------------------------------------------------------
// ppt_scan
// walks the table memory one slot a cycle, compares type and key, and
// tracks the lowest matching slot and the lowest free slot
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_scan import ppt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic                   cmp_type,
  input  wire logic [KEY_BITS-1:0]    cmp_key,
  input  wire logic [TABLE_DEPTH-1:0] valid_vec,
  output logic      [SLOT_W-1:0]      ram_raddr,
  input  wire logic [ENTRY_W-1:0]     ram_rdata,
  output ppt_scan_res_t               res
);

  logic              issue_r;
  logic [SLOT_W-1:0] addr_r;
  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_slot_r;

  logic match;
  logic last;
  logic done;
  logic cur_free;

  assign ram_raddr = addr_r;

  // compare stage on the registered read data
  always_comb begin
    match    = cmp_vld_r && valid_vec[cmp_idx_r]
               && (ram_rdata[ENTRY_W-1] == cmp_type)
               && (ram_rdata[KEY_BITS-1:0] == cmp_key);
    last     = (cmp_idx_r == SLOT_W'(TABLE_DEPTH - 1));
    done     = cmp_vld_r && (match || last);
    cur_free = cmp_vld_r && !valid_vec[cmp_idx_r];
  end

  // outcome toward the control
  always_comb begin
    res.done       = done;
    res.hit        = match;
    res.hit_slot   = cmp_idx_r;
    res.free_found = free_found_r || cur_free;
    res.free_slot  = free_found_r ? free_slot_r : cmp_idx_r;
  end

  // read issue and compare pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r      <= 1'b0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (go) begin
      issue_r      <= 1'b1;
      addr_r       <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (done) begin
      issue_r   <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue_r;
      cmp_idx_r <= addr_r;
      if (issue_r) begin
        addr_r <= addr_r + 1'b1;
        if (addr_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          issue_r <= 1'b0;
        end
      end
      // remember the lowest free slot seen so far
      if (cur_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= cmp_idx_r;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/pending_packet_table_core.sv
// A command (add, find or remove of a packet type and key) is taken while
// busy is low; its result shows on out_result for exactly one cycle with
// out_strobe high and cannot be held off, so the receiver must take it then.
// The table memory is read one slot per cycle from slot zero, stopping at the
// first match, and a command keeps busy high until its scan ends at a match
// or at the last slot; the next command may be started in the same cycle
// that the result is strobed.
// ----------------------------------------------------------------------------
// pending_packet_table_core
// pending packet table: command latch, valid bits, occupancy, write-back
// and result register around the table memory and its scanner
// ----------------------------------------------------------------------------
`default_nettype none

module pending_packet_table_core import ppt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire ppt_in_t in_item,
  output logic         out_strobe,
  output ppt_out_t     out_result
);

`include "pending_packet_table_core_defines.svh"

  logic                   busy_r;
  logic [CMD_W-1:0]       cmd_r;
  logic                   type_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] valid_nxt;
  logic [OCC_W-1:0]       count_r;
  logic [OCC_W-1:0]       count_nxt;
  logic                   out_strobe_r;
  ppt_out_t               out_result_r;
  ppt_out_t               result_nxt;

  logic                accept;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  logic [SLOT_W-1:0]   scan_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  ppt_scan_res_t       scan_res;

  assign accept     = start && !busy_r;
  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  // table memory holding type and key per slot
  assign ram_addr = ram_we ? scan_res.free_slot : scan_raddr;

  ppt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({type_r, key_r}),
    .rdata (ram_rdata)
  );

  ppt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .cmp_type  (type_r),
    .cmp_key   (key_r),
    .valid_vec (valid_r),
    .ram_raddr (scan_raddr),
    .ram_rdata (ram_rdata),
    .res       (scan_res)
  );

  // decide the outcome once the scan completes
  always_comb begin
    valid_nxt            = valid_r;
    count_nxt            = count_r;
    ram_we               = 1'b0;
    result_nxt.status    = ST_MISSING;
    result_nxt.slot      = '0;
    case (cmd_r)
      CMD_ADD: begin
        if (scan_res.hit) begin
          result_nxt.status = ST_FOUND;
          result_nxt.slot   = scan_res.hit_slot;
        end else if (scan_res.free_found) begin
          result_nxt.status               = ST_ADDED;
          result_nxt.slot                 = scan_res.free_slot;
          ram_we                          = scan_res.done;
          valid_nxt[scan_res.free_slot]   = 1'b1;
          count_nxt                       = count_r + 1'b1;
        end else begin
          result_nxt.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (scan_res.hit) begin
          result_nxt.status             = ST_REMOVED;
          result_nxt.slot               = scan_res.hit_slot;
          valid_nxt[scan_res.hit_slot]  = 1'b0;
          count_nxt                     = count_r - 1'b1;
        end
      end
      default: begin
        if (scan_res.hit) begin
          result_nxt.status = ST_FOUND;
          result_nxt.slot   = scan_res.hit_slot;
        end
      end
    endcase
    result_nxt.occupancy = count_nxt;
  end

  // command latch, key cut to the stored width
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_item.command;
      type_r <= in_item.pkt_type;
      key_r  <= in_item.match_key[KEY_BITS-1:0];
    end
  end

  // control state, valid bits, occupancy and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (busy_r && scan_res.done) begin
        busy_r       <= 1'b0;
        valid_r      <= valid_nxt;
        count_r      <= count_nxt;
        out_strobe_r <= 1'b1;
        out_result_r <= result_nxt;
      end
    end
  end

  `PPT_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe_r, !busy_r, "result strobed while busy")
  `PPT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_r, "accepted command did not set busy")
  `PPT_ASSERT_SAME(a_count_match, clk, rst_n, 1'b1, $countones(valid_r) == count_r, "occupancy does not match valid bits")
  `PPT_ASSERT_SAME(a_occ_range, clk, rst_n, out_strobe_r, out_result_r.occupancy <= OCC_W'(TABLE_DEPTH), "occupancy beyond table depth")

endmodule

`default_nettype wire

// File: test/tb_pending_packet_table_core.sv
// ----------------------------------------------------------------------------
// tb_pending_packet_table_core
// self-checking bench for the pending packet table: a short table of
// directed commands, then random episodes that fill the table past full,
// drain it and mix add, find and remove on stored and fresh keys; every
// result is compared with its directed row or a behavioral copy of the table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pending_packet_table_core import ppt_pkg::*; ();

  // spare command value, behaves as find
  localparam logic [CMD_W-1:0] CMD_SPARE    = 2'd3;
  localparam logic              PKT_INTEREST = 1'b0;
  localparam logic              PKT_DATA     = 1'b1;
  localparam logic [MKEY_W-1:0] KEY_ONES     = '1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    ppt_in_t  item;
    bit       typed;
    ppt_out_t want;
  } dir_row_t;

  localparam int N_DIRECTED = 24;

  // directed commands; typed rows carry their result, the rest use the table copy
  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    '{'{CMD_FIND,   PKT_INTEREST, 64'd0},     1'b1, '{ST_MISSING, 6'd0, 7'd0}},
    '{'{CMD_REMOVE, PKT_DATA,     KEY_ONES},  1'b1, '{ST_MISSING, 6'd0, 7'd0}},
    '{'{CMD_ADD,    PKT_INTEREST, 64'd0},     1'b1, '{ST_ADDED,   6'd0, 7'd1}},
    '{'{CMD_ADD,    PKT_DATA,     KEY_ONES},  1'b1, '{ST_ADDED,   6'd1, 7'd2}},
    '{'{CMD_ADD,    PKT_INTEREST, KEY_ONES},  1'b1, '{ST_ADDED,   6'd2, 7'd3}},
    '{'{CMD_ADD,    PKT_DATA,     64'd0},     1'b1, '{ST_ADDED,   6'd3, 7'd4}},
    '{'{CMD_ADD,    PKT_INTEREST, 64'd0},     1'b1, '{ST_FOUND,   6'd0, 7'd4}},
    '{'{CMD_FIND,   PKT_DATA,     KEY_ONES},  1'b1, '{ST_FOUND,   6'd1, 7'd4}},
    '{'{CMD_SPARE,  PKT_INTEREST, KEY_ONES},  1'b1, '{ST_FOUND,   6'd2, 7'd4}},
    '{'{CMD_SPARE,  PKT_DATA,     64'h1234},  1'b1, '{ST_MISSING, 6'd0, 7'd4}},
    '{'{CMD_FIND,   PKT_INTEREST, 64'h8000_0000_0000_0000},
                                              1'b1, '{ST_MISSING, 6'd0, 7'd4}},
    '{'{CMD_REMOVE, PKT_INTEREST, 64'd0},     1'b1, '{ST_REMOVED, 6'd0, 7'd3}},
    '{'{CMD_REMOVE, PKT_INTEREST, 64'd0},     1'b1, '{ST_MISSING, 6'd0, 7'd3}},
    '{'{CMD_FIND,   PKT_INTEREST, 64'd0},     1'b1, '{ST_MISSING, 6'd0, 7'd3}},
    '{'{CMD_ADD,    PKT_INTEREST, 64'hA5A5_A5A5_A5A5_A5A5},
                                              1'b1, '{ST_ADDED,   6'd0, 7'd4}},
    '{'{CMD_REMOVE, PKT_DATA,     KEY_ONES},  1'b1, '{ST_REMOVED, 6'd1, 7'd3}},
    '{'{CMD_ADD,    PKT_DATA,     64'h5A5A_5A5A_5A5A_5A5A},
                                              1'b1, '{ST_ADDED,   6'd1, 7'd4}},
    '{'{CMD_ADD,    PKT_INTEREST, 64'd1},     1'b1, '{ST_ADDED,   6'd4, 7'd5}},
    '{'{CMD_REMOVE, PKT_INTEREST, KEY_ONES},  1'b1, '{ST_REMOVED, 6'd2, 7'd4}},
    '{'{CMD_ADD,    PKT_DATA,     64'h8000_0000_0000_0000},
                                              1'b1, '{ST_ADDED,   6'd2, 7'd5}},
    '{'{CMD_FIND,   PKT_DATA,     64'h8000_0000_0000_0000},
                                              1'b1, '{ST_FOUND,   6'd2, 7'd5}},
    '{'{CMD_ADD,    PKT_DATA,     64'h0123_4567_89AB_CDEF},
                                              1'b0, '0},
    '{'{CMD_REMOVE, PKT_DATA,     64'd0},     1'b0, '0},
    '{'{CMD_SPARE,  PKT_INTEREST, 64'hA5A5_A5A5_A5A5_A5A5},
                                              1'b0, '0}
  };

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  ppt_in_t  in_item = '0;
  logic     busy;
  logic     out_strobe;
  ppt_out_t out_result;

  // behavioral copy of the table
  logic                tbl_valid [TABLE_DEPTH];
  logic                tbl_type  [TABLE_DEPTH];
  logic [KEY_BITS-1:0] tbl_key   [TABLE_DEPTH];
  int                  tbl_count;

  ppt_out_t          pending_results [$];
  logic [MKEY_W-1:0] key_pool [16];
  int                sent_count     = 0;
  int                accepted_count = 0;
  int                errors         = 0;
  int                cycle_count    = 0;
  bit                row_typed      = 1'b0;
  ppt_out_t          row_want       = '0;

  pending_packet_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apply one command to the table copy and return its result
  function automatic ppt_out_t apply_table_command(input ppt_in_t c);
    ppt_out_t r;
    int       hit;
    int       free_slot;
    r = '0;
    hit = -1;
    free_slot = -1;
    // walk downward so the lowest matching and lowest free slot win
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_type[i] == c.pkt_type &&
          tbl_key[i] == c.match_key[KEY_BITS-1:0])
        hit = i;
      if (!tbl_valid[i])
        free_slot = i;
    end
    case (c.command)
      CMD_ADD: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.slot   = SLOT_W'(hit);
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_type[free_slot]  = c.pkt_type;
          tbl_key[free_slot]   = c.match_key[KEY_BITS-1:0];
          tbl_count++;
          r.status = ST_ADDED;
          r.slot   = SLOT_W'(free_slot);
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          tbl_count--;
          r.status = ST_REMOVED;
          r.slot   = SLOT_W'(hit);
        end else begin
          r.status = ST_MISSING;
        end
      end
      default: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.slot   = SLOT_W'(hit);
        end else begin
          r.status = ST_MISSING;
        end
      end
    endcase
    r.occupancy = OCC_W'(tbl_count);
    return r;
  endfunction

  function automatic ppt_in_t make_item(input logic [CMD_W-1:0] cmd, input logic typ,
                                        input logic [MKEY_W-1:0] key);
    ppt_in_t c;
    c.command   = cmd;
    c.pkt_type  = typ;
    c.match_key = key;
    return c;
  endfunction

  // weighted command mix, spare value included
  function automatic logic [CMD_W-1:0] rand_cmd();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return CMD_ADD;
    if (pick < 6) return CMD_FIND;
    if (pick < 9) return CMD_REMOVE;
    return CMD_SPARE;
  endfunction

  function automatic logic [MKEY_W-1:0] random_key();
    logic [MKEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0, 1: k = {$urandom, $urandom};
      2:    k = key_pool[$urandom_range(0, 15)];
      default: begin
        // walking one or walking zero
        k = {{(MKEY_W-1){1'b0}}, 1'b1} << $urandom_range(0, MKEY_W - 1);
        if ($urandom_range(0, 1) == 1) k = ~k;
      end
    endcase
    return k;
  endfunction

  // command aimed at an entry that is currently stored, or a random one while the table is empty
  function automatic ppt_in_t stored_item(input logic [CMD_W-1:0] cmd);
    int idx;
    if (tbl_count == 0)
      return make_item(cmd, 1'($urandom_range(0, 1)), random_key());
    do idx = $urandom_range(0, TABLE_DEPTH - 1); while (!tbl_valid[idx]);
    return make_item(cmd, tbl_type[idx], MKEY_W'(tbl_key[idx]));
  endfunction

  // one command transfer, with an occasional gap ahead of it
  task automatic send_command(input ppt_in_t c, input bit typed, input ppt_out_t want);
    bit calm;
    calm = (sent_count >= 700 && sent_count < 1000);
    if (!calm && $urandom_range(0, 99) < 6) begin
      start   <= 1'b0;
      in_item <= make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           {$urandom, $urandom});
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    row_typed = typed;
    row_want  = want;
    in_item  <= c;
    start    <= 1'b1;
    sent_count++;
    @(posedge clk);
    while (busy) @(posedge clk);
    // let the table copy take this command before the next one is built
    wait (accepted_count == sent_count);
  endtask

  // hold off until every outstanding result has arrived
  task automatic quiesce();
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  // result check and prediction on accepted commands
  always @(posedge clk) begin
    ppt_out_t want;
    ppt_out_t got;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding: status %0d slot %0d occupancy %0d",
               out_result.status, out_result.slot, out_result.occupancy);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_result.status);
          errors++;
        end
        if (out_result.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, out_result.slot);
          errors++;
        end
        if (out_result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, out_result.occupancy);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      got = apply_table_command(in_item);
      // queue the expected result behind the ones still outstanding
      pending_results = {pending_results, (row_typed ? row_want : got)};
      accepted_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    int  n_total;
    bit  first_episode;
    logic [CMD_W-1:0] cmd;
    n_total = N_DIRECTED + RANDOM_ITEMS;
    first_episode = 1'b1;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_type[i]  = 1'b0;
      tbl_key[i]   = '0;
    end
    tbl_count = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIRECTED; r++)
      send_command(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);

    // random episodes
    while (sent_count < n_total) begin
      if (first_episode || $urandom_range(0, 5) == 0) quiesce();
      first_episode = 1'b0;
      case ($urandom_range(0, 3))
        0: begin
          // fill to the brim, then add against a full table
          while (tbl_count < TABLE_DEPTH && sent_count < n_total) begin
            if ($urandom_range(0, 7) == 0)
              send_command(stored_item(rand_cmd()), 1'b0, '0);
            else
              send_command(make_item(CMD_ADD, 1'($urandom_range(0, 1)), random_key()),
                           1'b0, '0);
          end
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
              send_command(stored_item(CMD_ADD), 1'b0, '0);
            else
              send_command(make_item(CMD_ADD, 1'($urandom_range(0, 1)), random_key()),
                           1'b0, '0);
          end
        end
        1: begin
          // drain the table, with some lookups of absent keys
          while (tbl_count > 0 && sent_count < n_total) begin
            if ($urandom_range(0, 5) == 0)
              send_command(make_item(rand_cmd(), 1'($urandom_range(0, 1)), random_key()),
                           1'b0, '0);
            else
              send_command(stored_item(CMD_REMOVE), 1'b0, '0);
          end
        end
        default: begin
          // mixed traffic, mostly on stored keys
          repeat (30) begin
            cmd = rand_cmd();
            if ($urandom_range(0, 3) != 0)
              send_command(stored_item(cmd), 1'b0, '0);
            else
              send_command(make_item(cmd, 1'($urandom_range(0, 1)), random_key()),
                           1'b0, '0);
          end
        end
      endcase
    end

    // wait out the last results and any stray strobe
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
